### hw/rtl/napt_pkg.sv
// shared types, constants and helpers for the napt translation table
package napt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [7:0] ST_INIT     = 8'hFF;
    localparam logic [7:0] ST_IN_FIN1  = 8'h01;
    localparam logic [7:0] ST_OUT_ACK1 = 8'h02;
    localparam logic [7:0] ST_OUT_FIN2 = 8'h03;
    localparam logic [7:0] ST_OUT_FIN1 = 8'h11;
    localparam logic [7:0] ST_IN_ACK1  = 8'h12;
    localparam logic [7:0] ST_IN_FIN2  = 8'h13;

    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_IP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAN_IP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_IDLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE   = 3'd4;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_fin;
        logic        flag_rst;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        logic [31:0] out_src_addr;
        logic [31:0] out_dst_addr;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] public_ip;
        logic [31:0] lan_ip;
        logic [5:0]  prefix_len;
        logic [15:0] udp_idle_secs;
        logic [15:0] port_base;
    } t_cfg;

    typedef struct packed {
        t_in_item item;
        logic     outbound;
    } t_q_ent;

    typedef struct packed {
        logic   vld;
        t_q_ent ent;
    } t_q_rd;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] stamp;
    } t_udp_ent;

    typedef struct packed {
        logic             valid;
        logic [31:0]      addr;
        logic [15:0]      port;
        logic [IDX_W-1:0] pidx;
        logic [7:0]       st;
    } t_tcp_ent;

    function automatic logic [15:0] pub_port(input logic [15:0] base,
                                             input logic [IDX_W-1:0] idx);
        return base + 16'(idx);
    endfunction

endpackage

### hw/rtl/napt_ifs.sv
// valid/ready channel interfaces for packets, results and config writes
interface napt_in_if;
    import napt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface napt_out_if;
    import napt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface napt_cfg_if;
    import napt_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/napt_front.sv
// front end: config registers, lan-side classification and packet queue
module napt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    napt_in_if.sink              i_in,
    napt_cfg_if.sink             i_cfg,
    input  logic                 i_pop,
    output napt_pkg::t_q_rd      o_q,
    output napt_pkg::t_cfg       o_cfg
);
    import napt_pkg::*;

    t_cfg        r_cfg;
    t_q_ent      r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [31:0] mask;
    logic        push;
    t_q_ent      ent;

    always_comb begin
        if (r_cfg.prefix_len == 6'd0) begin
            mask = '0;
        end else if (r_cfg.prefix_len >= 6'd32) begin
            mask = '1;
        end else begin
            mask = ~(32'hFFFF_FFFF >> r_cfg.prefix_len);
        end
    end

    assign ent.item     = i_in.data;
    assign ent.outbound = (i_in.data.src_addr & mask) == (r_cfg.lan_ip & mask);
    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign i_cfg.ready  = 1'b1;
    assign o_q.vld      = (r_cnt != 2'd0);
    assign o_q.ent      = r_mem[r_rp];
    assign o_cfg        = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.public_ip     <= '0;
            r_cfg.lan_ip        <= '0;
            r_cfg.prefix_len    <= 6'd24;
            r_cfg.udp_idle_secs <= 16'd30;
            r_cfg.port_base     <= 16'd10000;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_PUBLIC_IP:   r_cfg.public_ip     <= i_cfg.data.value;
                CFG_LAN_IP:      r_cfg.lan_ip        <= i_cfg.data.value;
                CFG_PREFIX_LEN:  r_cfg.prefix_len    <= i_cfg.data.value[5:0];
                CFG_UDP_IDLE:    r_cfg.udp_idle_secs <= i_cfg.data.value[15:0];
                CFG_PORT_BASE:   r_cfg.port_base     <= i_cfg.data.value[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

### hw/rtl/napt_back.sv
// back end: table sweep, mapping update and result register
module napt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  napt_pkg::t_q_rd i_q,
    input  napt_pkg::t_cfg  i_cfg,
    output logic            o_pop,
    napt_out_if.source      o_out
);
    import napt_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SWEEP, S_DONE} t_state;

    t_udp_ent udp_mem [TABLE_ENTRIES];
    t_tcp_ent tcp_mem [TABLE_ENTRIES];
    logic     pu_mem  [TABLE_ENTRIES];

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_q_vld;
    logic [IDX_W-1:0] r_q_idx;
    t_udp_ent         r_udp_q;
    t_tcp_ent         r_tcp_q;
    logic             r_pu_q;
    t_q_ent           r_item;
    logic             r_hit, r_uf, r_tf, r_pf;
    logic [IDX_W-1:0] r_hit_idx, r_uf_idx, r_tf_idx, r_pf_idx;
    t_udp_ent         r_hu;
    t_tcp_ent         r_ht;
    logic             r_out_vld;
    t_out_item        r_out;

    logic             u_we, t_we, p_we, p_wd;
    logic [IDX_W-1:0] u_wa, t_wa, p_wa, rd_addr;
    t_udp_ent         u_wd;
    t_tcp_ent         t_wd;
    logic             rd_en, is_udp, is_tcp, expired, u_live, match;
    logic             out_free, accept;
    logic [31:0]      osa, oda;
    logic [15:0]      osp, odp;
    t_in_item         it;

    assign it       = r_item.item;
    assign is_udp   = (it.protocol == PROTO_UDP);
    assign is_tcp   = (it.protocol == PROTO_TCP);
    assign rd_addr  = r_cnt[IDX_W-1:0];
    assign rd_en    = (r_state == S_SWEEP) && (r_cnt < CNT_W'(TABLE_ENTRIES));
    assign expired  = r_udp_q.valid &&
                      ((it.now_seconds - r_udp_q.stamp) > 32'(i_cfg.udp_idle_secs));
    assign u_live   = r_udp_q.valid && !expired;
    assign out_free = !r_out_vld || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && i_q.vld;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // match rule of the current entry depends on protocol and direction
    always_comb begin
        match = 1'b0;
        if (is_udp) begin
            if (r_item.outbound) begin
                match = u_live && r_udp_q.addr == it.src_addr && r_udp_q.port == it.src_port;
            end else begin
                match = u_live && pub_port(i_cfg.port_base, r_q_idx) == it.dst_port;
            end
        end else if (is_tcp) begin
            if (r_item.outbound) begin
                match = r_tcp_q.valid && r_tcp_q.addr == it.src_addr &&
                        r_tcp_q.port == it.src_port;
            end else begin
                match = r_tcp_q.valid &&
                        pub_port(i_cfg.port_base, r_tcp_q.pidx) == it.dst_port;
            end
        end
    end

    always_comb begin
        u_we = 1'b0; u_wa = r_q_idx; u_wd = r_udp_q;
        t_we = 1'b0; t_wa = r_hit_idx; t_wd = r_ht;
        p_we = 1'b0; p_wa = r_ht.pidx; p_wd = 1'b0;
        accept = 1'b0;
        osa = it.src_addr; oda = it.dst_addr; osp = it.src_port; odp = it.dst_port;
        case (r_state)
            S_CLEAR: begin
                u_we = 1'b1; u_wa = rd_addr; u_wd = '0;
                t_we = 1'b1; t_wa = rd_addr; t_wd = '0;
                p_we = 1'b1; p_wa = rd_addr; p_wd = 1'b0;
            end
            S_SWEEP: begin
                // lazy expiry as each entry goes by
                if (r_q_vld && expired) begin
                    u_we = 1'b1;
                    u_wd.valid = 1'b0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (is_udp && r_item.outbound) begin
                        if (r_hit || r_uf) begin
                            u_we = 1'b1;
                            u_wa = r_hit ? r_hit_idx : r_uf_idx;
                            u_wd = '{valid: 1'b1, addr: it.src_addr, port: it.src_port,
                                     stamp: it.now_seconds};
                            accept = 1'b1;
                            osa = i_cfg.public_ip;
                            osp = pub_port(i_cfg.port_base, u_wa);
                        end
                    end else if (is_udp) begin
                        if (r_hit &&
                            (it.now_seconds - r_hu.stamp) < 32'(i_cfg.udp_idle_secs)) begin
                            accept = 1'b1;
                            oda = r_hu.addr;
                            odp = r_hu.port;
                        end
                    end else if (is_tcp && r_hit) begin
                        accept = 1'b1;
                        if (r_item.outbound) begin
                            osa = i_cfg.public_ip;
                            osp = pub_port(i_cfg.port_base, r_ht.pidx);
                        end else begin
                            oda = r_ht.addr;
                            odp = r_ht.port;
                        end
                        if (it.flag_rst) begin
                            t_we = 1'b1; t_wd.valid = 1'b0; p_we = 1'b1;
                        end else if (r_item.outbound) begin
                            case (r_ht.st)
                                ST_INIT: begin
                                    t_we = it.flag_fin; t_wd.st = ST_OUT_FIN1;
                                end
                                ST_IN_FIN2: begin
                                    t_we = it.flag_ack; t_wd.valid = 1'b0; p_we = it.flag_ack;
                                end
                                ST_IN_FIN1: begin
                                    t_we = it.flag_ack;
                                    t_wd.st = it.flag_fin ? ST_OUT_FIN2 : ST_OUT_ACK1;
                                end
                                ST_OUT_ACK1: begin
                                    t_we = it.flag_fin; t_wd.st = ST_OUT_FIN2;
                                end
                                default: ;
                            endcase
                        end else begin
                            case (r_ht.st)
                                ST_INIT: begin
                                    t_we = it.flag_fin; t_wd.st = ST_IN_FIN1;
                                end
                                ST_OUT_FIN2: begin
                                    t_we = it.flag_ack; t_wd.valid = 1'b0; p_we = it.flag_ack;
                                end
                                ST_OUT_FIN1: begin
                                    t_we = it.flag_ack;
                                    t_wd.st = it.flag_fin ? ST_IN_FIN2 : ST_IN_ACK1;
                                end
                                ST_IN_ACK1: begin
                                    t_we = it.flag_fin; t_wd.st = ST_IN_FIN2;
                                end
                                default: ;
                            endcase
                        end
                    end else if (is_tcp && r_item.outbound && it.flag_syn && r_pf && r_tf) begin
                        t_we = 1'b1; t_wa = r_tf_idx;
                        t_wd = '{valid: 1'b1, addr: it.src_addr, port: it.src_port,
                                 pidx: r_pf_idx, st: ST_INIT};
                        p_we = 1'b1; p_wa = r_pf_idx; p_wd = 1'b1;
                        accept = 1'b1;
                        osa = i_cfg.public_ip;
                        osp = pub_port(i_cfg.port_base, r_pf_idx);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            udp_mem[u_wa] <= u_wd;
        end
        r_udp_q <= udp_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tcp_mem[t_wa] <= t_wd;
        end
        r_tcp_q <= tcp_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pu_mem[p_wa] <= p_wd;
        end
        r_pu_q <= pu_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_q_vld <= rd_en;
            r_q_idx <= rd_addr;
            if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q.vld) begin
                        r_item  <= i_q.ent;
                        r_cnt   <= '0;
                        r_hit   <= 1'b0;
                        r_uf    <= 1'b0;
                        r_tf    <= 1'b0;
                        r_pf    <= 1'b0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_q_vld) begin
                        if (match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_q_idx;
                            r_hu      <= r_udp_q;
                            r_ht      <= r_tcp_q;
                        end
                        if (!u_live && !r_uf) begin
                            r_uf     <= 1'b1;
                            r_uf_idx <= r_q_idx;
                        end
                        if (!r_tcp_q.valid && !r_tf) begin
                            r_tf     <= 1'b1;
                            r_tf_idx <= r_q_idx;
                        end
                        if (!r_pu_q && !r_pf) begin
                            r_pf     <= 1'b1;
                            r_pf_idx <= r_q_idx;
                        end
                    end else if (!rd_en) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        if (accept) begin
                            r_out <= '{verdict: 1'b1, out_src_addr: osa, out_dst_addr: oda,
                                       out_src_port: osp, out_dst_port: odp};
                        end else begin
                            r_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/napt_translation_table_top.sv
// top level of the napt translation table
// One packet header goes in per beat and one verdict with translated fields
// comes out per beat. After reset the block clears its UDP, TCP and
// port-bitmap memories and processes no packet in that time, though the
// front queue takes up to two; config writes are taken at any time the block
// is idle. Each packet then holds the back end while it is taken from the
// queue, through one sweep over the tables, each with one read and one write
// port, that reads one entry per cycle for lookup, free search and UDP
// expiry, and through the update. Its verdict is registered once the sweep
// ends, later only if the previous verdict is still waiting. A two-entry
// queue lets the front keep taking packets while the back end works, and
// the result register lets the next packet start while a verdict waits.
module napt_translation_table_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    napt_in_if.sink    i_in,
    napt_cfg_if.sink   i_cfg,
    napt_out_if.source o_out
);
    import napt_pkg::*;

    t_q_rd q;
    t_cfg  cfg;
    logic  pop;

    napt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_pop   (pop),
        .o_q     (q),
        .o_cfg   (cfg)
    );

    napt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .i_cfg   (cfg),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
